### hdl/swtm_pkg.sv
// Shared types and constants of the sliding-window throughput meter.
// Used by every module of the block; depends on nothing else.
package swtm_pkg;

  localparam int unsigned WINDOW_SLOTS_DEF = 5;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SLOT_W   = 32;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned RECENT_W = 32;

  localparam int unsigned IN_DATA_W  = TIME_W + COUNT_W;
  localparam int unsigned OUT_DATA_W = 2 * TOTAL_W + 2 * RECENT_W;

  localparam int unsigned DIV_DVD_W = TOTAL_W;
  localparam int unsigned DIV_DVS_W = TIME_W;

  // Event kinds as they arrive on the input channel.
  localparam logic [KIND_W-1:0] KIND_RX    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TX    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  typedef enum logic [1:0] {
    OP_RX,
    OP_TX,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [TIME_W-1:0]  now_sec;
    logic [COUNT_W-1:0] byte_count;
  } item_t;

endpackage

### hdl/swtm_div.sv
// Restoring divider of the throughput meter, one quotient bit per cycle.
// Depends on swtm_pkg for the default widths.
module swtm_div #(
  parameter int unsigned DVD_W = swtm_pkg::DIV_DVD_W,
  parameter int unsigned DVS_W = swtm_pkg::DIV_DVS_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  always_comb begin
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, dvd_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits DVS_W bits.
      if (!diff[DVS_W]) begin
        rem_d = diff[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

### hdl/swtm_front.sv
// Front end of the throughput meter: accepts events, classifies them and
// queues them for the back end. Depends on swtm_pkg.
module swtm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  logic [swtm_pkg::IN_DATA_W-1:0]      s_data_i,
  input  logic [swtm_pkg::KIND_W-1:0]         s_user_i,
  output logic                                item_valid_o,
  input  logic                                item_ready_i,
  output swtm_pkg::item_t                     item_o
);

  import swtm_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            queue_q [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  item_t            new_item;
  logic             keep;
  logic             push;
  logic             pop;

  // Unused kind codes are taken from the channel and dropped here.
  always_comb begin
    new_item.now_sec    = s_data_i[TIME_W-1:0];
    new_item.byte_count = s_data_i[TIME_W+COUNT_W-1:TIME_W];
    new_item.op         = OP_RX;
    keep                = 1'b1;
    case (s_user_i)
      KIND_RX:    new_item.op = OP_RX;
      KIND_TX:    new_item.op = OP_TX;
      KIND_QUERY: new_item.op = OP_QUERY;
      default:    keep = 1'b0;
    endcase
  end

  assign s_ready_o    = (count_q != CNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = s_valid_i && s_ready_o && keep;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

### hdl/swtm_back.sv
// Back end of the throughput meter: slot ring, totals, query sequencer with
// two dividers, and the output register. Depends on swtm_pkg and swtm_div.
module swtm_back #(
  parameter int unsigned WINDOW_SLOTS = swtm_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swtm_pkg::TIME_W-1:0]       cfg_data_i,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  swtm_pkg::item_t                   item_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [swtm_pkg::OUT_DATA_W-1:0]   m_data_o
);

  import swtm_pkg::*;

  localparam int unsigned PTR_W  = $clog2(WINDOW_SLOTS);
  localparam int unsigned STEP_W = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned SUM_W  = SLOT_W + $clog2(WINDOW_SLOTS);
  localparam logic [PTR_W:0] W_EXT = (PTR_W + 1)'(WINDOW_SLOTS);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SUM        = 3'd1;
  localparam logic [2:0] ST_DIV_AVG    = 3'd2;
  localparam logic [2:0] ST_DIV_RECENT = 3'd3;
  localparam logic [2:0] ST_OUT        = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [SLOT_W-1:0]     in_slots_q [WINDOW_SLOTS];
  logic [SLOT_W-1:0]     in_slots_d [WINDOW_SLOTS];
  logic [SLOT_W-1:0]     out_slots_q [WINDOW_SLOTS];
  logic [SLOT_W-1:0]     out_slots_d [WINDOW_SLOTS];
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [TIME_W-1:0]     last_sec_q, last_sec_d;
  logic [TOTAL_W-1:0]    total_in_q, total_in_d;
  logic [TOTAL_W-1:0]    total_out_q, total_out_d;
  logic [TIME_W-1:0]     connect_q, connect_d;
  logic [TIME_W-1:0]     span_q, span_d;
  logic [PTR_W-1:0]      rdiv_q, rdiv_d;
  logic [PTR_W-1:0]      idx_q, idx_d;
  logic [SUM_W-1:0]      sum_in_q, sum_in_d;
  logic [SUM_W-1:0]      sum_out_q, sum_out_d;
  logic [TOTAL_W-1:0]    avg_in_q, avg_in_d;
  logic [TOTAL_W-1:0]    avg_out_q, avg_out_d;
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // Ring advance for the item at the head of the queue.
  logic [TIME_W-1:0]  elapsed;
  logic [STEP_W-1:0]  steps;
  logic [PTR_W:0]     ptr_sum;
  logic [PTR_W:0]     ptr_wrap;
  logic [PTR_W-1:0]   new_ptr;
  logic [PTR_W:0]     offs_raw [WINDOW_SLOTS];
  logic [PTR_W:0]     offs [WINDOW_SLOTS];
  logic [SLOT_W-1:0]  in_adv [WINDOW_SLOTS];
  logic [SLOT_W-1:0]  out_adv [WINDOW_SLOTS];
  logic [SLOT_W:0]    in_add [WINDOW_SLOTS];
  logic [SLOT_W:0]    out_add [WINDOW_SLOTS];
  logic [SLOT_W-1:0]  in_upd [WINDOW_SLOTS];
  logic [SLOT_W-1:0]  out_upd [WINDOW_SLOTS];
  logic [TOTAL_W:0]   tot_in_add;
  logic [TOTAL_W:0]   tot_out_add;
  logic [TIME_W-1:0]  conn_diff;
  logic [TIME_W-1:0]  span_c;
  logic [TIME_W-1:0]  span_m1;
  logic [PTR_W-1:0]   rdiv_c;
  logic               fire;

  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_in_dvd;
  logic [DIV_DVD_W-1:0] div_out_dvd;
  logic [DIV_DVS_W-1:0] div_dvs;
  logic                 div_in_done;
  logic                 div_out_done;
  logic [DIV_DVD_W-1:0] div_in_q;
  logic [DIV_DVD_W-1:0] div_out_q;
  logic [RECENT_W-1:0]  rec_in;
  logic [RECENT_W-1:0]  rec_out;

  assign item_ready_o = (state_q == ST_IDLE);
  assign fire         = item_valid_i && item_ready_o;
  assign cfg_ready_o  = 1'b1;

  always_comb begin
    elapsed = item_i.now_sec - last_sec_q;
    if (elapsed[TIME_W-1] || (elapsed == '0)) begin
      steps = '0;
    end else if (elapsed >= TIME_W'(WINDOW_SLOTS)) begin
      steps = STEP_W'(WINDOW_SLOTS);
    end else begin
      steps = elapsed[STEP_W-1:0];
    end
    ptr_sum  = {1'b0, ptr_q} + (PTR_W + 1)'(steps);
    ptr_wrap = (ptr_sum >= W_EXT) ? ptr_sum - W_EXT : ptr_sum;
    new_ptr  = ptr_wrap[PTR_W-1:0];

    tot_in_add  = {1'b0, total_in_q} + (TOTAL_W + 1)'(item_i.byte_count);
    tot_out_add = {1'b0, total_out_q} + (TOTAL_W + 1)'(item_i.byte_count);

    // A slot is cleared when it lies within the next "steps" positions after
    // the old pointer; each slot works this out on its own.
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      offs_raw[i] = (PTR_W + 1)'(i) + W_EXT - (PTR_W + 1)'(1) - {1'b0, ptr_q};
      offs[i]     = (offs_raw[i] >= W_EXT) ? offs_raw[i] - W_EXT : offs_raw[i];
      if (offs[i] < (PTR_W + 1)'(steps)) begin
        in_adv[i]  = '0;
        out_adv[i] = '0;
      end else begin
        in_adv[i]  = in_slots_q[i];
        out_adv[i] = out_slots_q[i];
      end
      in_add[i]  = {1'b0, in_adv[i]} + (SLOT_W + 1)'(item_i.byte_count);
      out_add[i] = {1'b0, out_adv[i]} + (SLOT_W + 1)'(item_i.byte_count);
      in_upd[i]  = in_adv[i];
      out_upd[i] = out_adv[i];
      if (new_ptr == PTR_W'(i)) begin
        if (item_i.op == OP_RX) begin
          in_upd[i] = in_add[i][SLOT_W] ? '1 : in_add[i][SLOT_W-1:0];
        end
        if (item_i.op == OP_TX) begin
          out_upd[i] = out_add[i][SLOT_W] ? '1 : out_add[i][SLOT_W-1:0];
        end
      end
    end

    // Divisors of a query: span since connect, and the completed-slot count.
    conn_diff = item_i.now_sec - connect_q;
    span_c    = conn_diff[TIME_W-1] ? TIME_W'(1) : conn_diff + TIME_W'(1);
    span_m1   = span_c - TIME_W'(1);
    if (span_c > TIME_W'(WINDOW_SLOTS - 1)) begin
      rdiv_c = PTR_W'(WINDOW_SLOTS - 1);
    end else if (span_c > TIME_W'(1)) begin
      rdiv_c = span_m1[PTR_W-1:0];
    end else begin
      rdiv_c = PTR_W'(1);
    end
  end

  // The same two dividers first produce the average rates, then the recent ones.
  assign div_start   = ((state_q == ST_SUM) && (idx_q == PTR_W'(WINDOW_SLOTS - 1))) ||
                       ((state_q == ST_DIV_AVG) && div_in_done);
  assign div_in_dvd  = (state_q == ST_SUM) ? total_in_q : DIV_DVD_W'(sum_in_q);
  assign div_out_dvd = (state_q == ST_SUM) ? total_out_q : DIV_DVD_W'(sum_out_q);
  assign div_dvs     = (state_q == ST_SUM) ? span_q : DIV_DVS_W'(rdiv_q);

  assign rec_in  = (div_in_q[DIV_DVD_W-1:RECENT_W] != '0) ? '1 : div_in_q[RECENT_W-1:0];
  assign rec_out = (div_out_q[DIV_DVD_W-1:RECENT_W] != '0) ? '1 : div_out_q[RECENT_W-1:0];

  swtm_div #(
    .DVD_W (DIV_DVD_W),
    .DVS_W (DIV_DVS_W)
  ) u_div_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_in_done),
    .quotient_o (div_in_q)
  );

  swtm_div #(
    .DVD_W (DIV_DVD_W),
    .DVS_W (DIV_DVS_W)
  ) u_div_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_out_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_out_done),
    .quotient_o (div_out_q)
  );

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    last_sec_d  = last_sec_q;
    total_in_d  = total_in_q;
    total_out_d = total_out_q;
    connect_d   = connect_q;
    span_d      = span_q;
    rdiv_d      = rdiv_q;
    idx_d       = idx_q;
    sum_in_d    = sum_in_q;
    sum_out_d   = sum_out_q;
    avg_in_d    = avg_in_q;
    avg_out_d   = avg_out_q;
    m_valid_d   = m_valid_q && !m_ready_i;
    m_data_d    = m_data_q;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      in_slots_d[i]  = in_slots_q[i];
      out_slots_d[i] = out_slots_q[i];
    end

    if (cfg_valid_i) begin
      connect_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          ptr_d      = new_ptr;
          last_sec_d = item_i.now_sec;
          for (int i = 0; i < WINDOW_SLOTS; i++) begin
            in_slots_d[i]  = in_upd[i];
            out_slots_d[i] = out_upd[i];
          end
          case (item_i.op)
            OP_RX: begin
              total_in_d = tot_in_add[TOTAL_W] ? '1 : tot_in_add[TOTAL_W-1:0];
            end
            OP_TX: begin
              total_out_d = tot_out_add[TOTAL_W] ? '1 : tot_out_add[TOTAL_W-1:0];
            end
            OP_QUERY: begin
              span_d    = span_c;
              rdiv_d    = rdiv_c;
              idx_d     = '0;
              sum_in_d  = '0;
              sum_out_d = '0;
              state_d   = ST_SUM;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUM: begin
        if (idx_q != ptr_q) begin
          sum_in_d  = sum_in_q + SUM_W'(in_slots_q[idx_q]);
          sum_out_d = sum_out_q + SUM_W'(out_slots_q[idx_q]);
        end
        if (idx_q == PTR_W'(WINDOW_SLOTS - 1)) begin
          state_d = ST_DIV_AVG;
        end else begin
          idx_d = idx_q + PTR_W'(1);
        end
      end
      ST_DIV_AVG: begin
        if (div_in_done) begin
          avg_in_d  = div_in_q;
          avg_out_d = div_out_q;
          state_d   = ST_DIV_RECENT;
        end
      end
      ST_DIV_RECENT: begin
        if (div_in_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          m_data_d  = {rec_out, rec_in, avg_out_q, avg_in_q};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      last_sec_q  <= '0;
      total_in_q  <= '0;
      total_out_q <= '0;
      connect_q   <= '0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        in_slots_q[i]  <= '0;
        out_slots_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      last_sec_q  <= last_sec_d;
      total_in_q  <= total_in_d;
      total_out_q <= total_out_d;
      connect_q   <= connect_d;
      m_valid_q   <= m_valid_d;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        in_slots_q[i]  <= in_slots_d[i];
        out_slots_q[i] <= out_slots_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    span_q    <= span_d;
    rdiv_q    <= rdiv_d;
    idx_q     <= idx_d;
    sum_in_q  <= sum_in_d;
    sum_out_q <= sum_out_d;
    avg_in_q  <= avg_in_d;
    avg_out_q <= avg_out_d;
    m_data_q  <= m_data_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ptr_q} < W_EXT)
    else $error("slot pointer left the ring");

  a_totals_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_in_q >= $past(total_in_q)) && (total_out_q >= $past(total_out_q)))
    else $error("running total decreased");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_in_done || div_out_done) |->
      ((state_q == ST_DIV_AVG) || (state_q == ST_DIV_RECENT)) && (div_in_done == div_out_done))
    else $error("divider finished outside a divide step");

  a_result_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_valid_q && !m_ready_i) |=> (state_q == ST_OUT))
    else $error("pending result was overwritten");

endmodule

### hdl/sliding_window_throughput_meter_core.sv
// Top level of the sliding-window throughput meter.
// Depends on swtm_pkg, swtm_front, swtm_back and swtm_div.
//
// Usage: events enter on the s_axis channel (tuser holds the kind: receive,
// send or rate query; tdata holds now_sec and byte_count). Receive and send
// events update the per-second slot ring and the running totals and give no
// result. A query gives one result on the m_axis channel with the average
// and recent receive and send rates. The connection time is written on the
// cfg channel, which is always ready; write it only while the meter is idle.
// Events pass a two-entry queue, so transfers are accepted while the back end
// works. A byte event is registered in the queue before it reaches the back
// end, and byte events stream at one per cycle while no query is in progress.
// A query's result passes the queue, a sweep over the slots, two passes of the
// bit-serial 48-bit dividers at one quotient bit per cycle, and the hand-over
// to the output register.
// Reset clears the slots, totals, last second, connection time and queue.
// When the receiver stalls, the result waits in the output register and the
// back end holds the next query's result until that transfer completes.
module sliding_window_throughput_meter_core #(
  parameter int unsigned WINDOW_SLOTS = swtm_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: now_sec[31:0], byte_count[47:32]
  input  logic [swtm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [swtm_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: avg_in_rate[47:0], avg_out_rate[95:48], recent_in_rate[127:96],
  // recent_out_rate[159:128]
  output logic [swtm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swtm_pkg::TIME_W-1:0]       cfg_data_i
);

  import swtm_pkg::*;

  logic  item_valid;
  logic  item_ready;
  item_t item;

  swtm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  swtm_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata)
  );

endmodule

### bench/sliding_window_throughput_meter_core_tb.sv
// Self-checking bench for the sliding-window throughput meter core.
// Needs swtm_pkg and the core; a class inside the bench predicts every rate query.
`timescale 1ns / 100ps

module sliding_window_throughput_meter_core_tb;
  import swtm_pkg::*;

  localparam int unsigned SLOTS = WINDOW_SLOTS_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 255;
  // Idle wait after the last result, so the back end retires queued byte events.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Result fields as packed on m_axis_tdata; the last member sits in the lowest bits.
  typedef struct packed {
    logic [RECENT_W-1:0] recent_out;
    logic [RECENT_W-1:0] recent_in;
    logic [TOTAL_W-1:0]  avg_out;
    logic [TOTAL_W-1:0]  avg_in;
  } rates_t;

  class rate_checker;
    logic [SLOT_W-1:0]  in_slot[SLOTS];
    logic [SLOT_W-1:0]  out_slot[SLOTS];
    int unsigned        cur_slot;
    logic [TIME_W-1:0]  last_sec;
    logic [TIME_W-1:0]  connect_sec;
    logic [TOTAL_W-1:0] total_in;
    logic [TOTAL_W-1:0] total_out;
    rates_t             pending_rates[$];
    int unsigned        mismatches;
    int unsigned        rates_checked;
    int unsigned        byte_events;
    int unsigned        queries;
    int unsigned        connect_writes;

    function new();
      foreach (in_slot[i]) begin
        in_slot[i] = '0;
        out_slot[i] = '0;
      end
      cur_slot = 0;
      last_sec = '0;
      connect_sec = '0;
      total_in = '0;
      total_out = '0;
      mismatches = 0;
      rates_checked = 0;
      byte_events = 0;
      queries = 0;
      connect_writes = 0;
    endfunction

    function void set_connect_time(logic [TIME_W-1:0] t);
      connect_sec = t;
      connect_writes++;
    endfunction

    function int unsigned pending();
      return pending_rates.size();
    endfunction

    // Moves the ring forward by the seconds since the last event, at most one
    // full turn; a step back in time leaves the ring where it is.
    function void step_ring(logic [TIME_W-1:0] now);
      int elapsed;
      int steps;
      elapsed = $signed(now - last_sec);
      last_sec = now;
      steps = (elapsed > int'(SLOTS)) ? int'(SLOTS) : elapsed;
      for (int k = 0; k < steps; k++) begin
        cur_slot = (cur_slot + 1) % SLOTS;
        in_slot[cur_slot] = '0;
        out_slot[cur_slot] = '0;
      end
    endfunction

    function logic [TOTAL_W-1:0] sat_total(logic [TOTAL_W-1:0] a, logic [COUNT_W-1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + (TOTAL_W + 1)'(b);
      return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    function logic [SLOT_W-1:0] sat_slot(logic [SLOT_W-1:0] a, logic [COUNT_W-1:0] b);
      logic [SLOT_W:0] s;
      s = {1'b0, a} + (SLOT_W + 1)'(b);
      return s[SLOT_W] ? '1 : s[SLOT_W-1:0];
    endfunction

    function void note_event(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now,
                             logic [COUNT_W-1:0] count);
      op_e         op;
      longint      span;
      longint      rdiv;
      logic [63:0] sum_in;
      logic [63:0] sum_out;
      logic [63:0] a_in;
      logic [63:0] a_out;
      logic [63:0] q_in;
      logic [63:0] q_out;
      rates_t      r;
      op = op_e'(kind);
      case (op)
        OP_RX: begin
          step_ring(now);
          total_in = sat_total(total_in, count);
          in_slot[cur_slot] = sat_slot(in_slot[cur_slot], count);
          byte_events++;
        end
        OP_TX: begin
          step_ring(now);
          total_out = sat_total(total_out, count);
          out_slot[cur_slot] = sat_slot(out_slot[cur_slot], count);
          byte_events++;
        end
        OP_QUERY: begin
          // Seconds since connect, inclusive; a connect time in the future
          // counts as one second.
          span = longint'($signed(now - connect_sec)) + 1;
          if (span <= 0) span = 1;
          a_in = 64'(total_in) / 64'(span);
          a_out = 64'(total_out) / 64'(span);
          r.avg_in = a_in[TOTAL_W-1:0];
          r.avg_out = a_out[TOTAL_W-1:0];
          step_ring(now);
          sum_in = '0;
          sum_out = '0;
          for (int i = 0; i < int'(SLOTS); i++) begin
            if (i != int'(cur_slot)) begin
              sum_in += 64'(in_slot[i]);
              sum_out += 64'(out_slot[i]);
            end
          end
          if (span > longint'(SLOTS) - 1) rdiv = longint'(SLOTS) - 1;
          else if (span > 1) rdiv = span - 1;
          else rdiv = 1;
          q_in = sum_in / 64'(rdiv);
          q_out = sum_out / 64'(rdiv);
          r.recent_in = (q_in > 64'hFFFF_FFFF) ? '1 : q_in[RECENT_W-1:0];
          r.recent_out = (q_out > 64'hFFFF_FFFF) ? '1 : q_out[RECENT_W-1:0];
          pending_rates.push_back(r);
          queries++;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [TOTAL_W-1:0] want,
                                logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_rates(rates_t got);
      rates_t want;
      if (pending_rates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_rates.pop_front();
      rates_checked++;
      compare_field("avg_in_rate", want.avg_in, got.avg_in);
      compare_field("avg_out_rate", want.avg_out, got.avg_out);
      compare_field("recent_in_rate", 48'(want.recent_in), 48'(got.recent_in));
      compare_field("recent_out_rate", 48'(want.recent_out), 48'(got.recent_out));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [TIME_W-1:0]     cfg_data_i;

  int unsigned cycle_count = 0;
  int unsigned burst_left = 1;
  rate_checker meter = new();

  sliding_window_throughput_meter_core #(
    .WINDOW_SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      meter.check_rates(rates_t'(m_axis_tdata));
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // The receiver alternates long ready stretches with short on/off stalls.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(30, 200)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic write_connect_time(input logic [TIME_W-1:0] t);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= t;
    do @(posedge clk_i); while (!cfg_ready_o);
    meter.set_connect_time(t);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one event; the sender works in bursts with random gaps in between.
  task automatic push_event(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                            input logic [COUNT_W-1:0] count);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {count, now};
    do @(posedge clk_i); while (!s_axis_tready);
    meter.note_event(kind, now, count);
    burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 80);
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Holds the sender until every query has been answered and the back end
  // has retired the byte events still in flight.
  task automatic drain_meter();
    s_axis_tvalid <= 1'b0;
    while (meter.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  conn;
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
    int unsigned        n;
    int unsigned        pick;

    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= KIND_RX;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_connect_time(32'd100);
    // Empty meter, query before the connect time.
    push_event(KIND_QUERY, 32'd0, 16'hFFFF);
    // First events jump far ahead, so the ring turns a full round.
    push_event(KIND_RX, 32'd100, 16'hFFFF);
    push_event(KIND_TX, 32'd100, 16'h0000);
    push_event(KIND_RX, 32'd101, 16'h1234);
    push_event(KIND_TX, 32'd101, 16'hFFFF);
    push_event(KIND_QUERY, 32'd101, 16'h0000);
    push_event(KIND_RX, 32'd102, 16'hFFFF);
    push_event(KIND_QUERY, 32'd102, 16'h5555);
    push_event(KIND_QUERY, 32'd104, 16'hAAAA);
    // Time going backwards must not move the ring.
    push_event(KIND_RX, 32'd103, 16'd77);
    push_event(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    push_event(KIND_QUERY, 32'd103, 16'd0);
    push_event(KIND_RX, 32'hFFFF_FFFF, 16'h8000);
    push_event(KIND_QUERY, 32'hFFFF_FFFF, 16'd0);
    // Largest positive and most negative distances from the connect time.
    push_event(KIND_QUERY, 32'h7FFF_FFFF + 32'd100, 16'd0);
    push_event(KIND_TX, 32'h8000_0064, 16'd1);
    push_event(KIND_QUERY, 32'h8000_0064, 16'd0);
    push_event(KIND_QUERY, 32'h8000_0065, 16'd0);
    push_event(KIND_UNUSED, 32'd0, 16'd0);
    push_event(KIND_QUERY, 32'h8000_0066, 16'hFFFF);
    drain_meter();

    for (int phase = 0; phase < int'(NUM_PHASES); phase++) begin
      case (phase)
        0: conn = 32'hFFFF_FFFF;
        1: conn = 32'h0000_0000;
        2: conn = 32'h7FFF_FFF0;
        default: conn = $urandom();
      endcase
      write_connect_time(conn);
      // Start a little before or after the connect time.
      t = conn + $urandom_range(0, 12) - 32'd4;
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) t = t;
        else if (pick < 80) t = t + 32'd1;
        else if (pick < 90) t = t + $urandom_range(2, 7);
        else if (pick < 95) t = t - $urandom_range(1, 3);
        else if (pick < 97) t = t + $urandom_range(8, 5000);
        else t = $urandom();

        pick = $urandom_range(0, 99);
        if (pick < 40) kind = KIND_RX;
        else if (pick < 80) kind = KIND_TX;
        else if (pick < 97) kind = KIND_QUERY;
        else kind = KIND_UNUSED;

        pick = $urandom_range(0, 9);
        if (pick == 0) count = '0;
        else if (pick == 1) count = '1;
        else count = COUNT_W'($urandom_range(0, 65535));

        push_event(kind, t, count);
        if (kind != KIND_UNUSED) n++;
      end
      drain_meter();
    end

    $display("Run covered %0d byte events and %0d rate queries over %0d connect times,",
             meter.byte_events, meter.queries, meter.connect_writes);
    $display("with %0d results compared field by field.", meter.rates_checked);
    if (meter.mismatches == 0 && meter.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/swtm_pkg.sv
hdl/swtm_div.sv
hdl/swtm_front.sv
hdl/swtm_back.sv
hdl/sliding_window_throughput_meter_core.sv
bench/sliding_window_throughput_meter_core_tb.sv
